// File: rtl/core/rgbrle_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder package
// Shared payload types, status codes and sizing constants for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbrle_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int TOTAL_W      = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] RUN_FLAG     = 8'h80;
  localparam logic [7:0] RUN_LEN_MASK = 8'h7F;
  localparam logic [1:0] HEADER_LAST  = 2'(4 - 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_OVER_CAP  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel;
    logic [7:0]  repeat_count;
    logic        status_valid;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic      push;
    out_item_t item;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rgbrle_front.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder front end
// Accepts stream bytes, tracks header and run state, and builds result items.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  rgbrle_pkg::in_item_t   in_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [31:0]                  cfg_data,
  input  wire  rgbrle_pkg::q_stat_t    q_stat,
  output rgbrle_pkg::q_wr_t            q_wr
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CONTROL = 3'd1,
    PH_REP_LO  = 3'd2,
    PH_REP_HI  = 3'd3,
    PH_LIT_LO  = 3'd4,
    PH_LIT_HI  = 3'd5,
    PH_DRAIN   = 3'd6
  } phase_t;

  localparam int TW = rgbrle_pkg::TOTAL_W;

  phase_t                phase_r, phase_nxt;
  logic [1:0]            hidx_r, hidx_nxt;
  logic [TW-1:0]         decl_r, decl_nxt;
  logic [TW-1:0]         emit_r, emit_nxt;
  logic                  rep_r, rep_nxt;
  logic [7:0]            len_r, len_nxt;
  logic [7:0]            left_r, left_nxt;
  logic [7:0]            low_r, low_nxt;
  logic                  ovr_r, ovr_nxt;
  logic [2:0]            err_r, err_nxt;
  logic                  fin_r, fin_nxt;
  logic [31:0]           max_r;
  logic                  acc;
  logic                  pv;
  logic [15:0]           pix;
  logic [7:0]            cnt;
  logic [2:0]            status;
  logic [7:0]            b;

  assign in_stall  = q_stat.full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;
  assign b         = in_data.data_byte;

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    decl_nxt  = decl_r;
    emit_nxt  = emit_r;
    rep_nxt   = rep_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    low_nxt   = low_r;
    ovr_nxt   = ovr_r;
    err_nxt   = err_r;
    fin_nxt   = fin_r;
    pv        = 1'b0;
    pix       = '0;
    cnt       = '0;
    status    = rgbrle_pkg::ST_OK;

    case (phase_r)
      PH_HEADER: begin
        decl_nxt = decl_r | (TW'(b) << {hidx_r, 3'b000});
        hidx_nxt = hidx_r + 2'd1;
        if (hidx_r == rgbrle_pkg::HEADER_LAST) begin
          if (decl_nxt == '0) begin
            err_nxt   = (err_r == rgbrle_pkg::ST_OK) ? rgbrle_pkg::ST_EMPTY : err_r;
            phase_nxt = PH_DRAIN;
          end else if ((decl_nxt > max_r) ||
                       ((decl_nxt >> rgbrle_pkg::COUNT_BITS) != '0)) begin
            err_nxt   = (err_r == rgbrle_pkg::ST_OK) ? rgbrle_pkg::ST_OVER_CAP : err_r;
            phase_nxt = PH_DRAIN;
          end else begin
            phase_nxt = PH_CONTROL;
          end
        end
      end
      PH_CONTROL: begin
        if (!fin_r) begin
          rep_nxt   = (b & rgbrle_pkg::RUN_FLAG) != 8'd0;
          len_nxt   = (b & rgbrle_pkg::RUN_LEN_MASK) + 8'd1;
          left_nxt  = len_nxt;
          ovr_nxt   = ({1'b0, emit_r} + (TW + 1)'(len_nxt)) > {1'b0, decl_r};
          phase_nxt = rep_nxt ? PH_REP_LO : PH_LIT_LO;
        end
      end
      PH_REP_LO: begin
        low_nxt   = b;
        phase_nxt = PH_REP_HI;
      end
      PH_REP_HI: begin
        if (ovr_r) begin
          err_nxt   = (err_r == rgbrle_pkg::ST_OK) ? rgbrle_pkg::ST_OVERRUN : err_r;
          phase_nxt = PH_DRAIN;
        end else begin
          pv        = 1'b1;
          pix       = {b, low_r};
          cnt       = len_r;
          emit_nxt  = emit_r + TW'(len_r);
          phase_nxt = PH_CONTROL;
          fin_nxt   = emit_nxt == decl_r;
        end
      end
      PH_LIT_LO: begin
        low_nxt   = b;
        phase_nxt = PH_LIT_HI;
      end
      PH_LIT_HI: begin
        left_nxt = left_r - 8'd1;
        if (!ovr_r) begin
          pv       = 1'b1;
          pix      = {b, low_r};
          cnt      = 8'd1;
          emit_nxt = emit_r + TW'(1);
        end
        if (left_nxt == 8'd0) begin
          if (ovr_r) begin
            err_nxt   = (err_r == rgbrle_pkg::ST_OK) ? rgbrle_pkg::ST_OVERRUN : err_r;
            phase_nxt = PH_DRAIN;
          end else begin
            phase_nxt = PH_CONTROL;
            fin_nxt   = emit_nxt == decl_r;
          end
        end else begin
          phase_nxt = PH_LIT_LO;
        end
      end
      default: begin
      end
    endcase

    if (in_data.last) begin
      if (err_nxt != rgbrle_pkg::ST_OK) begin
        status = err_nxt;
      end else if (phase_nxt == PH_CONTROL && fin_nxt) begin
        status = rgbrle_pkg::ST_OK;
      end else begin
        status = rgbrle_pkg::ST_TRUNCATED;
      end
      phase_nxt = PH_HEADER;
      hidx_nxt  = '0;
      decl_nxt  = '0;
      emit_nxt  = '0;
      rep_nxt   = 1'b0;
      len_nxt   = '0;
      left_nxt  = '0;
      low_nxt   = '0;
      ovr_nxt   = 1'b0;
      err_nxt   = rgbrle_pkg::ST_OK;
      fin_nxt   = 1'b0;
    end
  end

  always_comb begin
    q_wr.push              = acc && (pv || in_data.last);
    q_wr.item.pixel_valid  = pv;
    q_wr.item.pixel        = pix;
    q_wr.item.repeat_count = cnt;
    q_wr.item.status_valid = in_data.last;
    q_wr.item.status       = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hidx_r  <= '0;
      decl_r  <= '0;
      emit_r  <= '0;
      rep_r   <= 1'b0;
      len_r   <= '0;
      left_r  <= '0;
      low_r   <= '0;
      ovr_r   <= 1'b0;
      err_r   <= rgbrle_pkg::ST_OK;
      fin_r   <= 1'b0;
      max_r   <= '1;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        hidx_r  <= hidx_nxt;
        decl_r  <= decl_nxt;
        emit_r  <= emit_nxt;
        rep_r   <= rep_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        low_r   <= low_nxt;
        ovr_r   <= ovr_nxt;
        err_r   <= err_nxt;
        fin_r   <= fin_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
    end
  end

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.last |=> phase_r == PH_HEADER && err_r == rgbrle_pkg::ST_OK)
    else $error("stream state not cleared after last byte");
  a_drain_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRAIN) == (err_r != rgbrle_pkg::ST_OK))
    else $error("drain phase and latched error disagree");
  a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= decl_r)
    else $error("emitted pixel count passed declared count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rgbrle_queue.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder result queue
// Short flop-based queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_queue (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  rgbrle_pkg::q_wr_t       q_wr,
  output rgbrle_pkg::q_stat_t           q_stat,
  input  wire                           pop,
  output rgbrle_pkg::out_item_t         rd_item
);

  localparam int D  = rgbrle_pkg::QUEUE_DEPTH;
  localparam int PW = rgbrle_pkg::QPTR_W;
  localparam int CW = rgbrle_pkg::QCNT_W;

  rgbrle_pkg::out_item_t  mem_r [D];
  logic [PW-1:0]          wptr_r, wptr_nxt;
  logic [PW-1:0]          rptr_r, rptr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == CW'(D);
  assign q_stat.empty = cnt_r == '0;
  assign rd_item      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (q_wr.push) begin
      wptr_nxt = (wptr_r == PW'(D - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(D - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (q_wr.push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !q_wr.push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (q_wr.push) begin
      mem_r[wptr_r] <= q_wr.item;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_stat.full)
    else $error("push into full result queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty result queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(D))
    else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rgbrle_back.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder output stage
// Pulls results from the queue into the output register and holds them
// while the result channel stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  rgbrle_pkg::q_stat_t     q_stat,
  input  wire  rgbrle_pkg::out_item_t   rd_item,
  output logic                          pop,
  output logic                          out_valid,
  input  wire                           out_stall,
  output rgbrle_pkg::out_item_t         out_data
);

  logic                  valid_r;
  rgbrle_pkg::out_item_t data_r;

  assign pop       = !q_stat.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (pop) begin
      data_r <= rd_item;
    end
  end

`ifndef SYNTH
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(data_r))
    else $error("stalled result lost or changed");
  a_fill_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped item did not reach output register");
  a_valid_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.pixel_valid || data_r.status_valid)
    else $error("output register holds an empty result");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rgb565_rle_decoder.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder
// Decodes a byte stream with a pixel-count header into repeat and literal
// pixel runs, with a final status on the last byte.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     in_data   (data_byte, last)
//   out      out_valid / out_stall   out_data  (pixel, count, status)
//   cfg      cfg_valid / cfg_ready   cfg_data  (max_pixels, 32 bits)
//
// One byte is accepted per cycle while in_stall is low; each byte yields at most one result.
// A result goes into the result queue when its byte is accepted, then into the output register on a pop.
// in_stall rises only when the two-entry result queue is full.
// Reset is synchronous and clears the stream state; max_pixels resets to all
// ones. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_rle_decoder (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  rgbrle_pkg::in_item_t   in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output rgbrle_pkg::out_item_t        out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [31:0]                  cfg_data
);

  rgbrle_pkg::q_wr_t     q_wr;
  rgbrle_pkg::q_stat_t   q_stat;
  rgbrle_pkg::out_item_t rd_item;
  logic                  pop;

  rgbrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_wr      (q_wr)
  );

  rgbrle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_stat  (q_stat),
    .pop     (pop),
    .rd_item (rd_item)
  );

  rgbrle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .rd_item   (rd_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
